// File: hw/rtl/akf_pkg.sv
// Shared types, constants and helpers for the angle/bias Kalman filter.
// Depends on nothing; every RTL file of the block imports it.
`default_nettype none

package akf_pkg;

    localparam int QW = 48;                     // Q16.32 internal word
    typedef logic signed [QW-1:0] t_q;

    localparam t_q MAX48 = {1'b0, {(QW-1){1'b1}}};
    localparam t_q MIN48 = {1'b1, {(QW-1){1'b0}}};

    // Register indexes of the configuration port.
    localparam logic [2:0] CFG_ANGLE_NOISE = 3'd0;
    localparam logic [2:0] CFG_BIAS_NOISE  = 3'd1;
    localparam logic [2:0] CFG_MEAS_NOISE  = 3'd2;
    localparam logic [2:0] CFG_PERIOD      = 3'd3;
    localparam logic [2:0] CFG_MEAS_GAIN   = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE, S_ISSUE, S_MWAIT, S_DIV, S_DWAIT, S_OUT
    } t_state;

    typedef enum logic [3:0] {
        OP_ANG, OP_P00, OP_P01, OP_P11, OP_PCT0, OP_PCT1, OP_E, OP_T1,
        OP_U00, OP_U01, OP_U10, OP_U11, OP_A, OP_B
    } t_op;

    // Request to the shared multiplier.
    typedef struct packed {
        logic start;
        logic sh16;   // rescale by 16 instead of 32
        logic neg_a;  // use -a in place of a
        t_q   a;
        t_q   b;
    } t_mul_req;

    // Request to the gain divider.
    typedef struct packed {
        logic start;
        t_q   n;
        t_q   d;
    } t_div_req;

    function automatic t_q sat48(input logic signed [QW+1:0] v);
        t_q r;
        if (v > $signed({{2{MAX48[QW-1]}}, MAX48})) begin
            r = MAX48;
        end else if (v < $signed({{2{MIN48[QW-1]}}, MIN48})) begin
            r = MIN48;
        end else begin
            r = v[QW-1:0];
        end
        return r;
    endfunction

    function automatic t_q add48(input t_q a, input t_q b);
        logic signed [QW+1:0] s;
        s = $signed({{2{a[QW-1]}}, a}) + $signed({{2{b[QW-1]}}, b});
        return sat48(s);
    endfunction

    function automatic t_q sub48(input t_q a, input t_q b);
        logic signed [QW+1:0] s;
        s = $signed({{2{a[QW-1]}}, a}) - $signed({{2{b[QW-1]}}, b});
        return sat48(s);
    endfunction

    function automatic logic [QW-1:0] mag48(input t_q v);
        return v[QW-1] ? (~v + 1'b1) : v;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/akf_mul.sv
// Shared multi-cycle multiplier: 48x48 signed, rescaled and saturated.
// One 24x24 partial product per cycle; depends on akf_pkg.
`default_nettype none

module akf_mul import akf_pkg::*; (
    input  wire      i_clk,
    input  wire      i_rst_n,
    input  t_mul_req i_req,
    output logic     o_done,
    output t_q       o_res
);

    logic            r_busy;
    logic [2:0]      r_cnt;
    logic [QW-1:0]   r_ua, r_ub;
    logic            r_neg, r_sh16;
    logic [2*QW-1:0] r_acc;
    logic            r_done;
    t_q              r_res;

    logic [23:0]     w_ah, w_bh;
    logic [47:0]     w_pp;
    logic [2*QW-1:0] w_pp_pos, w_m, w_limit;
    logic [QW-1:0]   w_mq;

    always_comb begin
        w_ah = r_cnt[1] ? r_ua[47:24] : r_ua[23:0];
        w_bh = r_cnt[0] ? r_ub[47:24] : r_ub[23:0];
        w_pp = w_ah * w_bh;
        case (r_cnt)
            3'd0:    w_pp_pos = {48'b0, w_pp};
            3'd3:    w_pp_pos = {w_pp, 48'b0};
            default: w_pp_pos = {24'b0, w_pp, 24'b0};
        endcase
        w_m     = r_sh16 ? (r_acc >> 16) : (r_acc >> 32);
        w_limit = r_neg ? {48'b0, 1'b1, 47'b0} : {48'b0, 1'b0, {47{1'b1}}};
        w_mq    = (w_m > w_limit) ? w_limit[QW-1:0] : w_m[QW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 3'd0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 3'd0;
            end else if (r_busy) begin
                if (r_cnt == 3'd4) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_ua   <= mag48(i_req.a);
            r_ub   <= mag48(i_req.b);
            r_neg  <= i_req.a[QW-1] ^ i_req.b[QW-1] ^ i_req.neg_a;
            r_sh16 <= i_req.sh16;
            r_acc  <= '0;
        end else if (r_busy) begin
            if (r_cnt == 3'd4) begin
                r_res <= r_neg ? t_q'(~w_mq + 1'b1) : t_q'(w_mq);
            end else begin
                r_acc <= r_acc + w_pp_pos;
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

`default_nettype wire

// File: hw/rtl/akf_div.sv
// Gain divider: (n * 2^32) / d, signed, truncated, saturated to 48 bits.
// Restoring division, one quotient bit per cycle; depends on akf_pkg.
`default_nettype none

module akf_div import akf_pkg::*; (
    input  wire      i_clk,
    input  wire      i_rst_n,
    input  t_div_req i_req,
    output logic     o_done,
    output t_q       o_res
);

    localparam int NB = QW + 32;   // dividend bits

    logic            r_busy, r_done;
    logic [6:0]      r_cnt;
    logic [NB-1:0]   r_num;
    logic [QW-1:0]   r_rem, r_q, r_ud;
    logic            r_ovf, r_neg, r_zero;
    t_q              r_res;

    logic [QW:0]     w_rr;
    logic            w_ge;
    logic [QW:0]     w_diff;
    logic [QW-1:0]   w_limit, w_qq;

    always_comb begin
        w_rr    = {r_rem, r_num[NB-1]};
        w_ge    = w_rr >= {1'b0, r_ud};
        w_diff  = w_rr - {1'b0, r_ud};
        w_limit = r_neg ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
        w_qq    = (r_ovf || (r_q > w_limit)) ? w_limit : r_q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 7'd0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'd0;
            end else if (r_busy) begin
                if (r_cnt == 7'(NB)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + 7'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num  <= {mag48(i_req.n), 32'b0};
            r_ud   <= mag48(i_req.d);
            r_neg  <= i_req.n[QW-1] ^ i_req.d[QW-1];
            r_zero <= (i_req.d == '0);
            r_rem  <= '0;
            r_q    <= '0;
            r_ovf  <= 1'b0;
        end else if (r_busy) begin
            if (r_cnt == 7'(NB)) begin
                if (r_zero) begin
                    r_res <= '0;
                end else begin
                    r_res <= r_neg ? t_q'(~w_qq + 1'b1) : t_q'(w_qq);
                end
            end else begin
                r_rem <= w_ge ? w_diff[QW-1:0] : w_rr[QW-1:0];
                r_q   <= {r_q[QW-2:0], w_ge};
                r_ovf <= r_ovf | r_q[QW-1];
                r_num <= {r_num[NB-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

`default_nettype wire

// File: hw/rtl/angle_bias_kalman_filter.sv
// Two-state angle/gyro-bias Kalman filter, top level; uses akf_pkg, akf_mul, akf_div.
// Each accepted request runs fourteen multiplications on the shared multiplier and
// two divisions on the bit-serial divider, then loads the output register once it
// is free. The block takes no new request until the current one is done; the next
// request is taken the cycle after the result is registered. Reset (synchronous,
// active low) restores the configuration, filter state and control registers.
`default_nettype none

module angle_bias_kalman_filter import akf_pkg::*; (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // Configuration write port.
    input  wire         i_cfg_we,
    input  wire  [2:0]  i_cfg_index,
    input  wire  [31:0] i_cfg_data,
    // Input requests.
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [55:0] s_axis_tdata,   // [24:0] accel_angle, [49:25] gyro_rate, zero pad
    // Results.
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [63:0] m_axis_tdata    // [31:0] filtered_angle, [63:32] filtered_rate
);

    // Configuration registers.
    logic [31:0] r_qa, r_qg, r_rn, r_dt;
    logic [17:0] r_c;

    // Filter state and per-request working values, all Q16.32.
    t_q r_ang, r_bias, r_paa, r_pab, r_pba, r_pbb;
    t_q r_meas, r_rate, r_err, r_pct0, r_pct1, r_e, r_k0, r_k1, r_t1;

    t_state r_state, n_state;
    t_op    r_op, n_op;
    logic   r_div_sel, n_div_sel;

    logic        r_out_valid;
    logic [31:0] r_out_angle, r_out_rate;

    logic     w_accept, w_load_out;
    t_mul_req w_mul_req;
    t_div_req w_div_req;
    logic     w_mul_done, w_div_done;
    t_q       w_mul_res, w_div_res;

    t_q w_dt, w_qa, w_qg, w_c, w_rq, w_ang_new, w_corr, w_d00;
    logic signed [QW+1:0] w_d00_sum;

    assign w_accept = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);

    // Widened register values in Q16.32 (the measurement gain stays Q16.16).
    assign w_dt = {16'b0, r_dt};
    assign w_qa = {16'b0, r_qa};
    assign w_qg = {16'b0, r_qg};
    assign w_c  = {30'b0, r_c};
    // R in Q16.32 saturates once it reaches 2^31 in Q16.16.
    assign w_rq = r_rn[31] ? MAX48 : {r_rn, 16'b0};

    assign w_corr    = sub48(r_rate, r_bias);
    assign w_ang_new = add48(r_ang, w_mul_res);

    // The angle covariance slope is summed at full width and saturated once.
    assign w_d00_sum = $signed({{2{w_qa[QW-1]}}, w_qa})
                     - $signed({{2{r_pab[QW-1]}}, r_pab})
                     - $signed({{2{r_pba[QW-1]}}, r_pba});
    assign w_d00 = sat48(w_d00_sum);

    // Truncation toward zero from Q16.32 to Q16.16.
    function automatic logic [31:0] to_q16(input t_q v);
        return v[47:16] + {31'b0, (v[47] && (v[15:0] != 16'b0))};
    endfunction

    akf_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mul_req),
        .o_done  (w_mul_done),
        .o_res   (w_mul_res)
    );

    akf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_done  (w_div_done),
        .o_res   (w_div_res)
    );

    // Operand selection for the shared multiplier. The sequence first predicts
    // the angle and the covariance, then forms C*P terms and the innovation
    // variance, and after the two gains corrects covariance and estimates.
    always_comb begin
        w_mul_req       = '0;
        w_mul_req.start = (r_state == S_ISSUE);
        case (r_op)
            OP_ANG:  begin w_mul_req.a = w_corr; w_mul_req.b = w_dt; end
            OP_P00:  begin
                w_mul_req.a = w_d00;
                w_mul_req.b = w_dt;
            end
            OP_P01:  begin
                w_mul_req.a     = r_pbb;
                w_mul_req.neg_a = 1'b1;
                w_mul_req.b     = w_dt;
            end
            OP_P11:  begin w_mul_req.a = w_qg; w_mul_req.b = w_dt; end
            OP_PCT0: begin w_mul_req.a = w_c; w_mul_req.b = r_paa;  w_mul_req.sh16 = 1'b1; end
            OP_PCT1: begin w_mul_req.a = w_c; w_mul_req.b = r_pba;  w_mul_req.sh16 = 1'b1; end
            OP_E:    begin w_mul_req.a = w_c; w_mul_req.b = r_pct0; w_mul_req.sh16 = 1'b1; end
            OP_T1:   begin w_mul_req.a = w_c; w_mul_req.b = r_pab;  w_mul_req.sh16 = 1'b1; end
            OP_U00:  begin w_mul_req.a = r_k0; w_mul_req.b = r_pct0; end
            OP_U01:  begin w_mul_req.a = r_k0; w_mul_req.b = r_t1; end
            OP_U10:  begin w_mul_req.a = r_k1; w_mul_req.b = r_pct0; end
            OP_U11:  begin w_mul_req.a = r_k1; w_mul_req.b = r_t1; end
            OP_A:    begin w_mul_req.a = r_k0; w_mul_req.b = r_err; end
            OP_B:    begin w_mul_req.a = r_k1; w_mul_req.b = r_err; end
            default: begin w_mul_req.a = '0; w_mul_req.b = '0; end
        endcase

        w_div_req.start = (r_state == S_DIV);
        w_div_req.n     = r_div_sel ? r_pct1 : r_pct0;
        w_div_req.d     = r_e;
    end

    // Sequencer: next state, next operation and strobes.
    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_div_sel  = r_div_sel;
        w_load_out = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_ISSUE;
                    n_op    = OP_ANG;
                end
            end
            S_ISSUE: n_state = S_MWAIT;
            S_MWAIT: begin
                if (w_mul_done) begin
                    case (r_op)
                        OP_E: begin
                            n_state   = S_DIV;
                            n_div_sel = 1'b0;
                        end
                        OP_B: n_state = S_OUT;
                        default: begin
                            n_state = S_ISSUE;
                            n_op    = t_op'(r_op + 4'd1);
                        end
                    endcase
                end
            end
            S_DIV: n_state = S_DWAIT;
            S_DWAIT: begin
                if (w_div_done) begin
                    if (!r_div_sel) begin
                        n_state   = S_DIV;
                        n_div_sel = 1'b1;
                    end else begin
                        n_state = S_ISSUE;
                        n_op    = OP_T1;
                    end
                end
            end
            S_OUT: begin
                // Hold until the output register is free.
                if (!r_out_valid || m_axis_tready) begin
                    w_load_out = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_op      <= OP_ANG;
            r_div_sel <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_op      <= n_op;
            r_div_sel <= n_div_sel;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qa <= 32'd4294967;
            r_qg <= 32'd12884902;
            r_rn <= 32'd32768;
            r_dt <= 32'd21474836;
            r_c  <= 18'd65536;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ANGLE_NOISE: r_qa <= i_cfg_data;
                CFG_BIAS_NOISE:  r_qg <= i_cfg_data;
                CFG_MEAS_NOISE:  r_rn <= i_cfg_data;
                CFG_PERIOD:      r_dt <= i_cfg_data;
                CFG_MEAS_GAIN:   r_c  <= i_cfg_data[17:0];
                default: ;
            endcase
        end
    end

    // Filter state: written back from the shared multiplier as each step completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ang  <= '0;
            r_bias <= '0;
            r_paa  <= t_q'(64'h1_0000_0000);
            r_pab  <= '0;
            r_pba  <= '0;
            r_pbb  <= t_q'(64'h1_0000_0000);
        end else if (r_state == S_MWAIT && w_mul_done) begin
            case (r_op)
                OP_ANG: r_ang <= w_ang_new;
                OP_P00: r_paa <= add48(r_paa, w_mul_res);
                OP_P01: begin
                    r_pab <= add48(r_pab, w_mul_res);
                    r_pba <= add48(r_pba, w_mul_res);
                end
                OP_P11: r_pbb  <= add48(r_pbb, w_mul_res);
                OP_U00: r_paa  <= sub48(r_paa, w_mul_res);
                OP_U01: r_pab  <= sub48(r_pab, w_mul_res);
                OP_U10: r_pba  <= sub48(r_pba, w_mul_res);
                OP_U11: r_pbb  <= sub48(r_pbb, w_mul_res);
                OP_A:   r_ang  <= w_ang_new;
                OP_B:   r_bias <= add48(r_bias, w_mul_res);
                default: ;
            endcase
        end
    end

    // Working values of the current request.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_meas <= {{7{s_axis_tdata[24]}}, s_axis_tdata[24:0], 16'b0};
            r_rate <= {{7{s_axis_tdata[49]}}, s_axis_tdata[49:25], 16'b0};
        end
        if (r_state == S_MWAIT && w_mul_done) begin
            case (r_op)
                OP_ANG:  r_err  <= sub48(r_meas, w_ang_new);
                OP_PCT0: r_pct0 <= w_mul_res;
                OP_PCT1: r_pct1 <= w_mul_res;
                OP_E:    r_e    <= add48(w_rq, w_mul_res);
                OP_T1:   r_t1   <= w_mul_res;
                default: ;
            endcase
        end
        if (r_state == S_DWAIT && w_div_done) begin
            if (r_div_sel) begin
                r_k1 <= w_div_res;
            end else begin
                r_k0 <= w_div_res;
            end
        end
        if (w_load_out) begin
            r_out_angle <= to_q16(r_ang);
            r_out_rate  <= to_q16(w_corr);
        end
    end

    // Output register: holds a result until the consumer takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_rate, r_out_angle};

    // A request puts the block busy on the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !s_axis_tready)
        else $error("block ready right after accepting a request");

    // The multiplier only finishes while the sequencer waits on it.
    a_mul_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_done |-> (r_state == S_MWAIT))
        else $error("multiplier result outside its wait state");

    // The divider only finishes while the sequencer waits on it.
    a_div_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DWAIT))
        else $error("divider result outside its wait state");

endmodule

`default_nettype wire

// File: test/tb.sv
// Testbench for angle_bias_kalman_filter: a bit-exact predictor of the two-state
// angle/bias filter checks every result. Depends on akf_pkg and the filter RTL.
`timescale 1ns / 100ps

module tb;
    import akf_pkg::*;

    localparam int LATENCY  = 300;
    localparam int WD_LIMIT = 4000;
    localparam int N_RANDOM = 1500;

    // A register index that the block does not decode.
    localparam logic [2:0] CFG_UNKNOWN = 3'd7;

    typedef logic signed [47:0] t_q48;

    typedef struct packed {
        logic [31:0] rate;
        logic [31:0] angle;
    } t_filt_out;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [31:0] i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;

    angle_bias_kalman_filter u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Predictor state: configuration registers as written, and filter state in Q16.32 in 48 bits.
    logic [31:0] q_angle, q_bias, r_meas, dt_reg;
    logic [17:0] c_gain;
    t_q48        est_angle, est_bias, p00, p01, p10, p11;

    t_filt_out   expected_q[$];
    int          n_mismatch;
    int          n_idle;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Saturate a wide signed value to the 48-bit range.
    function automatic t_q48 clamp48(input logic signed [127:0] v);
        if (v > 128'sh7FFF_FFFF_FFFF) return 48'sh7FFF_FFFF_FFFF;
        if (v < -128'sh8000_0000_0000) return 48'sh8000_0000_0000;
        return v[47:0];
    endfunction

    // Product rescaled toward zero by sh bits, then saturated.
    function automatic t_q48 mul_rescale(input logic signed [63:0] a,
                                         input logic signed [63:0] b, input int sh);
        logic signed [127:0] p;
        logic [127:0]        m;
        p = 128'(a) * 128'(b);
        m = p < 0 ? -p : p;
        m = m >> sh;
        return p < 0 ? clamp48(-$signed(m)) : clamp48($signed(m));
    endfunction

    // Gain = (n << 32) / d toward zero, saturated; a zero divisor gives zero.
    function automatic t_q48 gain_quot(input t_q48 n, input t_q48 d);
        logic signed [127:0] num, q;
        if (d == 0) return '0;
        num = 128'(n) <<< 32;
        q = num / 128'(d);
        return clamp48(q);
    endfunction

    function automatic logic [31:0] to_q16(input t_q48 v);
        logic [47:0] m;
        m = v < 0 ? -v : v;
        m = m >> 16;
        return v < 0 ? 32'(-m) : 32'(m);
    endfunction

    task automatic reset_model();
        q_angle = 32'd4294967;
        q_bias = 32'd12884902;
        r_meas = 32'd32768;
        dt_reg = 32'd21474836;
        c_gain = 18'd65536;
        est_angle = '0;
        est_bias = '0;
        p00 = 48'sh1_0000_0000;
        p01 = '0;
        p10 = '0;
        p11 = 48'sh1_0000_0000;
    endtask

    // One filter step; returns the expected output pair.
    function automatic t_filt_out kalman_step(input logic signed [24:0] acc,
                                              input logic signed [24:0] gyr);
        t_q48 meas, rate, dt, c, rq, corr, err, d00, pc0, pc1, e, k0, k1, t1;
        t_filt_out r;
        meas = t_q48'(acc) <<< 16;
        rate = t_q48'(gyr) <<< 16;
        dt = {16'd0, dt_reg};
        c = {30'd0, c_gain};
        rq = clamp48(128'(r_meas) << 16);
        corr = clamp48(128'(rate) - 128'(est_bias));
        est_angle = clamp48(128'(est_angle) + 128'(mul_rescale(corr, dt, 32)));
        err = clamp48(128'(meas) - 128'(est_angle));
        d00 = clamp48(128'($signed({16'd0, q_angle})) - 128'(p01) - 128'(p10));
        p00 = clamp48(128'(p00) + 128'(mul_rescale(d00, dt, 32)));
        p01 = clamp48(128'(p01) + 128'(mul_rescale(-p11, dt, 32)));
        p10 = clamp48(128'(p10) + 128'(mul_rescale(-p11, dt, 32)));
        p11 = clamp48(128'(p11) + 128'(mul_rescale($signed({16'd0, q_bias}), dt, 32)));
        pc0 = mul_rescale(c, p00, 16);
        pc1 = mul_rescale(c, p10, 16);
        e = clamp48(128'(rq) + 128'(mul_rescale(c, pc0, 16)));
        k0 = gain_quot(pc0, e);
        k1 = gain_quot(pc1, e);
        t1 = mul_rescale(c, p01, 16);
        p00 = clamp48(128'(p00) - 128'(mul_rescale(k0, pc0, 32)));
        p01 = clamp48(128'(p01) - 128'(mul_rescale(k0, t1, 32)));
        p10 = clamp48(128'(p10) - 128'(mul_rescale(k1, pc0, 32)));
        p11 = clamp48(128'(p11) - 128'(mul_rescale(k1, t1, 32)));
        est_angle = clamp48(128'(est_angle) + 128'(mul_rescale(k0, err, 32)));
        est_bias = clamp48(128'(est_bias) + 128'(mul_rescale(k1, err, 32)));
        corr = clamp48(128'(rate) - 128'(est_bias));
        r.angle = to_q16(est_angle);
        r.rate = to_q16(corr);
        return r;
    endfunction

    // Send one request after a random gap; the prediction is queued on acceptance.
    task automatic send_sample(input logic signed [24:0] acc, input logic signed [24:0] gyr);
        int gap;
        gap = $urandom_range(0, 3);
        if ($urandom_range(0, 3) == 0) gap = 0;
        repeat (gap) @(posedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {6'd0, gyr, acc};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        expected_q.push_back(kalman_step(acc, gyr));
        s_axis_tvalid <= 1'b0;
        // The block is busy right after a request, so this edge costs nothing.
        @(posedge i_clk);
    endtask

    task automatic drain();
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    // Registers are written only while the filter is idle.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_ANGLE_NOISE: q_angle = val;
            CFG_BIAS_NOISE:  q_bias = val;
            CFG_MEAS_NOISE:  r_meas = val;
            CFG_PERIOD:      dt_reg = val;
            CFG_MEAS_GAIN:   c_gain = val[17:0];
            default: ;
        endcase
    endtask

    function automatic logic signed [24:0] rand_angle();
        return 25'($signed($urandom_range(0, 23592960)) - 11796480);
    endfunction

    function automatic logic signed [24:0] rand_rate();
        return 25'($signed($urandom_range(0, 32768000)) - 16384000);
    endfunction

    task automatic test_directed();
        logic signed [24:0] acc_vals[5];
        logic signed [24:0] gyr_vals[4];
        acc_vals = '{-25'sd11796480, 25'sd11796480, 25'sd0, -25'sd1, 25'sd1};
        gyr_vals = '{25'sd16384000, -25'sd16384000, 25'sd0, -25'sd1};
        foreach (acc_vals[i]) send_sample(acc_vals[i], gyr_vals[i % 4]);
        // The sender holds off until every result is back.
        drain();
        foreach (gyr_vals[i]) send_sample(-acc_vals[i], gyr_vals[i]);
    endtask

    // Zero gain with zero noise makes the innovation variance zero.
    task automatic test_zero_divisor();
        write_reg(CFG_MEAS_GAIN, 32'd0);
        write_reg(CFG_MEAS_NOISE, 32'd0);
        repeat (4) send_sample(rand_angle(), rand_rate());
        write_reg(CFG_UNKNOWN, 32'hFFFF_FFFF);   // ignored by the block
        write_reg(CFG_MEAS_GAIN, 32'd131072);
        repeat (4) send_sample(rand_angle(), rand_rate());
    endtask

    // Extreme settings drive the covariance and estimates into saturation.
    task automatic test_extreme_config();
        write_reg(CFG_ANGLE_NOISE, 32'hFFFF_FFFF);
        write_reg(CFG_BIAS_NOISE, 32'hFFFF_FFFF);
        write_reg(CFG_MEAS_NOISE, 32'hFFFF_FFFF);
        write_reg(CFG_PERIOD, 32'hFFFF_FFFF);
        repeat (6) send_sample(rand_angle(), rand_rate());
        write_reg(CFG_ANGLE_NOISE, 32'd0);
        write_reg(CFG_BIAS_NOISE, 32'd0);
        write_reg(CFG_PERIOD, 32'd0);
        write_reg(CFG_MEAS_NOISE, 32'd1);
        repeat (4) send_sample(rand_angle(), rand_rate());
    endtask

    task automatic test_random();
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i % 300 == 0) begin
                write_reg(CFG_ANGLE_NOISE, $urandom());
                write_reg(CFG_BIAS_NOISE, $urandom());
                write_reg(CFG_MEAS_NOISE, i == 0 ? 32'd32768 : $urandom_range(0, 32'h00FF_FFFF));
                write_reg(CFG_PERIOD, i == 0 ? 32'd21474836 : $urandom_range(0, 32'h1000_0000));
                write_reg(CFG_MEAS_GAIN, $urandom_range(0, 131072));
            end
            send_sample(rand_angle(), rand_rate());
        end
    endtask

    // Result side: after each result, ready drops for a randomly drawn hold (possibly none);
    // compare against the oldest prediction.
    initial begin
        t_filt_out got, want;
        int        hold;
        m_axis_tready = 1'b0;
        n_mismatch = 0;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata;
                if (expected_q.size() == 0) begin
                    n_mismatch++;
                    if (n_mismatch <= 10) $display("unexpected result %h", got);
                end else begin
                    want = expected_q.pop_front();
                    if (got.angle !== want.angle || got.rate !== want.rate) begin
                        n_mismatch++;
                        if (n_mismatch <= 10)
                            $display("mismatch angle exp %h got %h, rate exp %h got %h",
                                     want.angle, got.angle, want.rate, got.rate);
                    end
                end
                hold = $urandom_range(0, 3);
                if (hold != 0) m_axis_tready <= 1'b0;
            end else if (!m_axis_tready) begin
                if (hold > 0) hold--;
                if (hold == 0) m_axis_tready <= 1'b1;
            end
        end
    end

    // Watchdog: cycles with no accepted request, result or configuration write.
    initial begin
        n_idle = 0;
        forever begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || i_cfg_we)
                n_idle = 0;
            else
                n_idle++;
            if (n_idle >= WD_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        reset_model();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_zero_divisor();
        test_extreme_config();
        test_random();
        drain();
        if (n_mismatch == 0 && expected_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
